// File: design/wake_pkg.sv
// Shared constants and types for the WAKE CFB stream cipher.
// Used by the controller, datapath and top level.
package wake_pkg;
	localparam logic [1:0] OP_REKEY = 2'd0;
	localparam logic [1:0] OP_IV    = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	localparam logic [31:0] MASK_LO24 = 32'h00ffffff;
	localparam logic [31:0] MASK_B23  = 32'hff7fffff;
	localparam logic [31:0] Z_OR      = 32'h01000001;

	// key schedule table indexes
	localparam logic [8:0] TBL_GEN_LAST  = 9'd255;
	localparam logic [8:0] TBL_ADD_LAST  = 9'd22;
	localparam logic [8:0] TBL_ADD_OFS   = 9'd89;
	localparam logic [8:0] TBL_X_IDX     = 9'd33;
	localparam logic [8:0] TBL_Z_IDX     = 9'd59;
	localparam logic [8:0] TBL_COPY      = 9'd256;
	localparam logic [8:0] TBL_PERM_LAST = 9'd255;

	// datapath commands
	localparam logic [3:0] CMD_NONE   = 4'd0;
	localparam logic [3:0] CMD_LOADK  = 4'd1;  // write key word p, load chain
	localparam logic [3:0] CMD_READ   = 4'd2;  // table read at addr
	localparam logic [3:0] CMD_GEN    = 4'd3;  // table[p] from table[p-4], table[p-1]
	localparam logic [3:0] CMD_ADD    = 4'd4;  // table[p] += table[p+89]
	localparam logic [3:0] CMD_XZ     = 4'd5;  // capture x = t[33], z from t[59]
	localparam logic [3:0] CMD_MASK   = 4'd6;  // masking pass write
	localparam logic [3:0] CMD_COPY   = 4'd7;  // t[256] = t[0], x8 from x
	localparam logic [3:0] CMD_PX     = 4'd8;  // perm: read t[p^x]
	localparam logic [3:0] CMD_PXN    = 4'd9;  // perm: new x, read t[x]
	localparam logic [3:0] CMD_PLO    = 4'd10; // perm: t[p] = t[x], read t[p+1]
	localparam logic [3:0] CMD_PHI    = 4'd11; // perm: t[x] = t[p+1]
	localparam logic [3:0] CMD_BYTE   = 4'd12; // process one CFB byte
	localparam logic [3:0] CMD_MXR    = 4'd13; // mix: read t[s & 0xff]
	localparam logic [3:0] CMD_MIX    = 4'd14; // one chained mix step

	typedef struct packed {
		logic [3:0] cmd;
		logic [8:0] addr;   // table address for read or write
		logic [1:0] sub;    // sub step / chain select
		logic       fb_in;  // feedback is input byte
	} wake_cmd_t;

	function automatic logic [31:0] tt(input logic [2:0] i);
		case (i)
			3'd0: tt = 32'h726a8f3b;
			3'd1: tt = 32'he69a3b5c;
			3'd2: tt = 32'hd3c71fe5;
			3'd3: tt = 32'hab3c73d2;
			3'd4: tt = 32'h4d3a8eb3;
			3'd5: tt = 32'h0396d6e8;
			3'd6: tt = 32'h3d4c2f7a;
			default: tt = 32'h9ee27cf3;
		endcase
	endfunction
endpackage

// File: design/wake_ctrl.sv
// Sequencer for the WAKE CFB cipher: key schedule steps and byte handling.
// Depends on wake_pkg; drives wake_dp by command structs.
module wake_ctrl import wake_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  op,
	input  logic        mode,
	input  logic        wrap,      // byte position about to wrap
	input  logic        out_full,  // output byte still waiting
	output logic        busy,
	output logic        out_load,
	output wake_cmd_t   cmd
);
	localparam logic [4:0] S_IDLE = 5'd0, S_LK = 5'd1, S_GR0 = 5'd2, S_GR1 = 5'd3,
		S_GW = 5'd4, S_AR0 = 5'd5, S_AR1 = 5'd6, S_AW = 5'd7, S_XR0 = 5'd8,
		S_XR1 = 5'd9, S_XZ = 5'd10, S_MR = 5'd11, S_MW = 5'd12, S_PR0 = 5'd13,
		S_PR1 = 5'd14, S_PW0 = 5'd15, S_PW1 = 5'd16, S_BY = 5'd17, S_MXR = 5'd18,
		S_MXW = 5'd19;

	logic [4:0] state_q;
	logic [8:0] p_q;
	logic [1:0] sub_q;
	logic       fb_q, data_q;
	logic       hold_out;

	// a data byte waits in S_BY until the output register is free
	assign hold_out = data_q && out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q <= '0;
			sub_q <= '0;
			fb_q <= 1'b0;
			data_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					p_q <= '0;
					sub_q <= '0;
					fb_q <= (op == OP_DATA) && mode;
					data_q <= (op == OP_DATA);
					if (op == OP_REKEY) state_q <= S_LK;
					else if (op == OP_IV || op == OP_DATA) state_q <= S_BY;
				end
				S_LK: begin
					p_q <= p_q + 9'd1;
					if (p_q == 9'd3) state_q <= S_GR0;
				end
				S_GR0: state_q <= S_GR1;
				S_GR1: state_q <= S_GW;
				S_GW: begin
					if (p_q == TBL_GEN_LAST) begin
						p_q <= '0;
						state_q <= S_AR0;
					end else begin
						p_q <= p_q + 9'd1;
						state_q <= S_GR0;
					end
				end
				S_AR0: state_q <= S_AR1;
				S_AR1: state_q <= S_AW;
				S_AW: begin
					if (p_q == TBL_ADD_LAST) begin
						p_q <= '0;
						state_q <= S_XR0;
					end else begin
						p_q <= p_q + 9'd1;
						state_q <= S_AR0;
					end
				end
				S_XR0: state_q <= S_XR1;
				S_XR1: state_q <= S_XZ;
				S_XZ: state_q <= S_MR;
				S_MR: state_q <= S_MW;
				S_MW: begin
					// last pass write goes to 256 as copy of 0
					if (p_q == TBL_COPY) begin
						p_q <= '0;
						state_q <= S_PR0;
					end else begin
						p_q <= p_q + 9'd1;
						state_q <= S_MR;
					end
				end
				S_PR0: state_q <= S_PR1;
				S_PR1: state_q <= S_PW0;
				S_PW0: state_q <= S_PW1;
				S_PW1: begin
					if (p_q == TBL_PERM_LAST) state_q <= S_IDLE;
					else begin
						p_q <= p_q + 9'd1;
						state_q <= S_PR0;
					end
				end
				S_BY: if (!hold_out) state_q <= wrap ? S_MXR : S_IDLE;
				S_MXR: state_q <= S_MXW;
				S_MXW: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) state_q <= S_IDLE;
					else state_q <= S_MXR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign out_load = (state_q == S_BY) && data_q && !out_full;

	always_comb begin
		cmd.cmd = CMD_NONE;
		cmd.addr = p_q;
		cmd.sub = sub_q;
		cmd.fb_in = fb_q;
		unique case (state_q)
			S_LK:  cmd.cmd = CMD_LOADK;
			S_GR0: begin cmd.cmd = CMD_READ; cmd.addr = p_q - 9'd4; end
			S_GR1: begin cmd.cmd = CMD_READ; cmd.addr = p_q - 9'd1; end
			S_GW:  cmd.cmd = CMD_GEN;
			S_AR0: cmd.cmd = CMD_READ;
			S_AR1: begin cmd.cmd = CMD_READ; cmd.addr = p_q + TBL_ADD_OFS; end
			S_AW:  cmd.cmd = CMD_ADD;
			S_XR0: begin cmd.cmd = CMD_READ; cmd.addr = TBL_X_IDX; end
			S_XR1: begin cmd.cmd = CMD_READ; cmd.addr = TBL_Z_IDX; end
			S_XZ:  cmd.cmd = CMD_XZ;
			S_MR: begin
				cmd.cmd = CMD_READ;
				cmd.addr = (p_q == TBL_COPY) ? 9'd0 : p_q;
			end
			S_MW:  cmd.cmd = (p_q == TBL_COPY) ? CMD_COPY : CMD_MASK;
			S_PR0: cmd.cmd = CMD_PX;
			S_PR1: cmd.cmd = CMD_PXN;
			S_PW0: cmd.cmd = CMD_PLO;
			S_PW1: cmd.cmd = CMD_PHI;
			S_BY:  cmd.cmd = hold_out ? CMD_NONE : CMD_BYTE;
			S_MXR: cmd.cmd = CMD_MXR;
			S_MXW: cmd.cmd = CMD_MIX;
			default: cmd.cmd = CMD_NONE;
		endcase
	end
endmodule

// File: design/wake_dp.sv
// Datapath for the WAKE CFB cipher: mixing table memory, chain registers,
// feedback word and byte counter. Depends on wake_pkg; driven by wake_ctrl.
module wake_dp import wake_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wake_cmd_t   cmd,
	input  logic [31:0] key0,
	input  logic [31:0] key1,
	input  logic [31:0] key2,
	input  logic [31:0] key3,
	input  logic [7:0]  in_byte_q,
	output logic        wrap,
	output logic [7:0]  out_byte
);
	logic [31:0] mem [0:256];
	logic [31:0] rd_q;               // registered read port
	logic [8:0]  ra, wa;
	logic        re, we;
	logic [31:0] wd;

	logic [31:0] a_q, b_q, c_q, d_q, fb_q;
	logic [1:0]  pos_q;
	logic [31:0] hold_q;             // first operand of a two-read step
	logic [31:0] x_q, z_q;
	logic [7:0]  x8_q;

	logic [31:0] gsum, xs, mix_s, mix_prev, mix_new, fb_new;
	logic [7:0]  ks, ob, fbb, xn;
	logic [4:0]  sh;

	assign sh = {pos_q, 3'b000};
	assign ks = 8'(d_q >> sh);
	assign ob = in_byte_q ^ ks;
	assign fbb = cmd.fb_in ? in_byte_q : ob;
	assign fb_new = (fb_q & ~(32'hff << sh)) | (32'(fbb) << sh);
	assign wrap = (pos_q == 2'd3);
	assign gsum = hold_q + rd_q;
	assign xs = (x_q & MASK_B23) + z_q;
	assign xn = rd_q[7:0] ^ x8_q;

	always_comb begin
		case (cmd.sub)
			2'd0: mix_prev = fb_q;
			2'd1: mix_prev = a_q;
			2'd2: mix_prev = b_q;
			default: mix_prev = c_q;
		endcase
		case (cmd.sub)
			2'd0: mix_s = a_q + mix_prev;
			2'd1: mix_s = b_q + mix_prev;
			2'd2: mix_s = c_q + mix_prev;
			default: mix_s = d_q + mix_prev;
		endcase
		mix_new = ((mix_s >> 8) & MASK_LO24) ^ rd_q;
	end

	// read address selection
	always_comb begin
		re = 1'b0;
		ra = cmd.addr;
		unique case (cmd.cmd)
			CMD_READ: re = 1'b1;
			CMD_PX: begin re = 1'b1; ra = {1'b0, cmd.addr[7:0] ^ x8_q}; end
			CMD_PXN: begin re = 1'b1; ra = {1'b0, xn}; end
			CMD_PLO: begin re = 1'b1; ra = cmd.addr + 9'd1; end
			CMD_MXR: begin re = 1'b1; ra = {1'b0, mix_s[7:0]}; end
			default: re = 1'b0;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = cmd.addr;
		wd = rd_q;
		unique case (cmd.cmd)
			CMD_LOADK: begin
				we = 1'b1;
				case (cmd.addr[1:0])
					2'd0: wd = key0;
					2'd1: wd = key1;
					2'd2: wd = key2;
					default: wd = key3;
				endcase
			end
			CMD_GEN: begin we = 1'b1; wd = (gsum >> 3) ^ tt(gsum[2:0]); end
			CMD_ADD: begin we = 1'b1; wd = gsum; end
			CMD_MASK: begin we = 1'b1; wd = (rd_q & MASK_LO24) ^ xs; end
			CMD_COPY: we = 1'b1;
			CMD_PLO: we = 1'b1;
			CMD_PHI: begin we = 1'b1; wa = {1'b0, x8_q}; end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	assign out_byte = ob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			fb_q <= '0; pos_q <= '0;
		end else begin
			case (cmd.cmd)
				CMD_LOADK: begin
					a_q <= key0; b_q <= key1; c_q <= key2; d_q <= key3;
					fb_q <= '0; pos_q <= '0;
				end
				CMD_BYTE: begin
					fb_q <= fb_new;
					pos_q <= pos_q + 2'd1;
				end
				CMD_MIX: begin
					case (cmd.sub)
						2'd0: a_q <= mix_new;
						2'd1: b_q <= mix_new;
						2'd2: c_q <= mix_new;
						default: d_q <= mix_new;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.cmd)
			CMD_READ: hold_q <= rd_q;
			CMD_XZ: begin
				x_q <= hold_q;
				z_q <= (rd_q | Z_OR) & MASK_B23;
			end
			CMD_MASK: x_q <= xs;
			CMD_COPY: x8_q <= x_q[7:0];
			CMD_PXN: x8_q <= xn;
			default: ;
		endcase
	end
endmodule

// File: design/wake_cfb_stream_cipher.sv
// WAKE CFB stream cipher, byte-wide stream in and out. A rekey is paced by the
// single read port of the 257-word table: each generated or added word takes two
// reads and a write, and each masked word a read and a write. On every fourth
// data or IV byte the four chained table mixes run a read and a write each. A
// data byte holds in its output step while the previous output byte is not yet
// taken. Write configuration only while the block is idle.
// Top level: wake_ctrl sequencer plus wake_dp datapath; uses wake_pkg.
module wake_cfb_stream_cipher import wake_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [1:0] op, [9:2] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] key0_q, key1_q, key2_q, key3_q;
	logic        mode_q;
	logic [7:0]  in_q;
	logic        busy, out_load, wrap, start, out_full;
	logic [7:0]  ob;
	wake_cmd_t   cmd;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;
	assign out_full = m_axis_tvalid && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			mode_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_KEY0: key0_q <= cfg_data;
					REG_KEY1: key1_q <= cfg_data;
					REG_KEY2: key2_q <= cfg_data;
					REG_KEY3: key3_q <= cfg_data;
					REG_MODE: mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_load) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) in_q <= s_axis_tdata[9:2];
		if (out_load) m_axis_tdata <= ob;
	end

	wake_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(s_axis_tdata[1:0]),
		.mode(mode_q), .wrap(wrap), .out_full(out_full), .busy(busy),
		.out_load(out_load), .cmd(cmd)
	);

	wake_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .key0(key0_q), .key1(key1_q),
		.key2(key2_q), .key3(key3_q), .in_byte_q(in_q), .wrap(wrap), .out_byte(ob)
	);
endmodule
